// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Command and status codes, controller states and the control/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL_DROP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_POP = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } dq_state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic rd_en;
    logic load;
  } dq_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;
  } dq_stat_t;

endpackage

// ----- rtl/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl: sequencing controller
// Takes one word, runs the update, the registered memory read and the
// load of the output register, then returns to idle.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dq_stat_t stat,
  output dq_ctrl_t ctl
);

  dq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.exec  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // wait for the output register to free up
        if (!stat.out_blocked) begin
          ctl.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath: ring storage, head and count registers, output register
// Executes one command per exec strobe, reads front and back entries on
// rd_en and formats the result word on load.
// ----------------------------------------------------------------------------
module dq_datapath
  import dq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_ctrl_t                   ctl,
  output dq_stat_t                   stat,
  input  logic [CMD_W-1:0]           cmd,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic signed [VALUE_W-1:0]  back_value,
  output logic [COUNT_W-1:0]         count,
  output logic                       is_empty,
  output logic [STATUS_W-1:0]        status
);

  localparam int HW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_S   = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [HW-1:0] LAST_H  = HW'(CAPACITY - 1);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [HW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [DATA_WIDTH-1:0] wr_data;
  logic [HW-1:0]         wr_addr;
  logic                  wr_en;

  logic [HW-1:0] head_dec, head_inc, tail_addr, back_addr;
  logic [SW-1:0] sum_tail, sum_back;

  logic [DATA_WIDTH-1:0] rd_front_r, rd_back_r;
  logic [VALUE_W-1:0]    front_ext, back_ext;
  logic [COUNT_W-1:0]    count_out;

  logic                      out_valid_r;
  logic [VALUE_W-1:0]        out_front_r, out_back_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_empty_r;
  logic [STATUS_W-1:0]       out_status_r;

  logic full, empty;

  // value kept in DATA_WIDTH bits
  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_wr_narrow
      assign wr_data = value[DATA_WIDTH-1:0];
    end else begin : g_wr_wide
      assign wr_data = {{(DATA_WIDTH-VALUE_W){1'b0}}, value};
    end
  endgenerate

  // sign extend or truncate to the 32-bit result fields
  generate
    if (DATA_WIDTH >= VALUE_W) begin : g_rd_wide
      assign front_ext = rd_front_r[VALUE_W-1:0];
      assign back_ext  = rd_back_r[VALUE_W-1:0];
    end else begin : g_rd_narrow
      assign front_ext = {{(VALUE_W-DATA_WIDTH){rd_front_r[DATA_WIDTH-1]}}, rd_front_r};
      assign back_ext  = {{(VALUE_W-DATA_WIDTH){rd_back_r[DATA_WIDTH-1]}}, rd_back_r};
    end
  endgenerate

  generate
    if (CW >= COUNT_W) begin : g_cnt_wide
      assign count_out = count_r[COUNT_W-1:0];
    end else begin : g_cnt_narrow
      assign count_out = {{(COUNT_W-CW){1'b0}}, count_r};
    end
  endgenerate

  assign full  = (count_r == CAP_C);
  assign empty = (count_r == '0);

  // ring index arithmetic, every sum that is used stays below twice the capacity
  always_comb begin
    head_dec = (head_r == '0) ? LAST_H : head_r - 1'b1;
    head_inc = (head_r == LAST_H) ? '0 : head_r + 1'b1;

    sum_tail  = {{(SW-HW){1'b0}}, head_r} + {1'b0, count_r};
    tail_addr = (sum_tail >= CAP_S) ? HW'(sum_tail - CAP_S) : sum_tail[HW-1:0];

    sum_back = sum_tail - 1'b1;
    if (count_r == '0) begin
      back_addr = head_r;
    end else if (sum_back >= CAP_S) begin
      back_addr = HW'(sum_back - CAP_S);
    end else begin
      back_addr = sum_back[HW-1:0];
    end
  end

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = tail_addr;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL_DROP;
        end else begin
          head_nxt  = head_dec;
          wr_addr   = head_dec;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL_DROP;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY_POP;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY_POP;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (ctl.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_r <= status_nxt;
    end
  end

  // ring storage: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_front_r <= mem[head_r];
      rd_back_r  <= mem[back_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_front_r  <= empty ? '1 : front_ext;
      out_back_r   <= empty ? '1 : back_ext;
      out_count_r  <= count_out;
      out_empty_r  <= empty;
      out_status_r <= status_r;
    end
  end

  assign stat.out_blocked = out_valid_r && !out_tready;

  assign out_tvalid  = out_valid_r;
  assign front_value = out_front_r;
  assign back_value  = out_back_r;
  assign count       = out_count_r;
  assign is_empty    = out_empty_r;
  assign status      = out_status_r;

endmodule

// ----- rtl/double_ended_queue.sv -----
// An accepted input word updates head and count, then the ring is read, then the
//   result word is loaded into the output register and offered from there.
// A new word is taken only once the controller has stepped through its read and
//   hold steps back to idle; the hold step lasts while the output stalls.
// Reset: synchronous, active low; clears head, count, controller state and
//   output valid. Ring entries are not cleared; their contents reach the output only once written.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed values
// Ring of CAPACITY entries with head index and count; one result word per
// input word with front, back, count, empty flag and status.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [34:3] value, [39:35] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] front_value, [63:32] back_value, [68:64] count, [69] is_empty,
  // [71:70] status
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  dq_ctrl_t ctl;
  dq_stat_t stat;

  logic signed [VALUE_W-1:0] front_value, back_value;
  logic [COUNT_W-1:0]        count;
  logic                      is_empty;
  logic [STATUS_W-1:0]       status;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  dq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (in_tdata[CMD_W-1:0]),
    .value       (in_tdata[CMD_W+VALUE_W-1:CMD_W]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

  assign out_tdata = {status, is_empty, count, back_value, front_value};

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for double_ended_queue
// Feeds push, pop and idle words through the input stream with random gaps,
// stalls the result stream at random, and compares every result word field
// by field against a ring-buffer deque tracked alongside the design.
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_OPS     = 1725;

  // one result word, laid out exactly as out_tdata
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  back_value;
    logic [VALUE_W-1:0]  front_value;
  } deque_view_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    int                 gap;
    bit                 drain_first;
  } deque_op_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  double_ended_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow deque
  logic [VALUE_W-1:0] ring [CAPACITY_DEF];
  int                 head_idx = 0;
  int                 held = 0;

  deque_op_t   pending_ops[$];
  deque_view_t expected_views[$];

  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int n_push = 0, n_pop = 0, n_full_drop = 0, n_empty_pop = 0, n_noop = 0;
  int peak_held = 0;

  bit in_took = 1'b0;
  bit out_took = 1'b0;
  int in_wait = 0;
  int out_wait = 0;

  function automatic deque_view_t deque_apply(logic [CMD_W-1:0] cmd,
                                              logic [VALUE_W-1:0] value);
    deque_view_t v;
    v = '0;
    v.status = ST_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held == CAPACITY_DEF) begin
          v.status = ST_FULL_DROP;
          n_full_drop++;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head_idx = (head_idx + CAPACITY_DEF - 1) % CAPACITY_DEF;
            ring[head_idx] = value;
          end else begin
            ring[(head_idx + held) % CAPACITY_DEF] = value;
          end
          held++;
          n_push++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (held == 0) begin
          v.status = ST_EMPTY_POP;
          n_empty_pop++;
        end else begin
          if (cmd == CMD_POP_FRONT) head_idx = (head_idx + 1) % CAPACITY_DEF;
          held--;
          n_pop++;
        end
      end
      default: n_noop++;
    endcase
    if (held > peak_held) peak_held = held;
    if (held == 0) begin
      v.front_value = '1;
      v.back_value  = '1;
      v.is_empty    = 1'b1;
    end else begin
      v.front_value = ring[head_idx];
      v.back_value  = ring[(head_idx + held - 1) % CAPACITY_DEF];
      v.is_empty    = 1'b0;
    end
    v.count = COUNT_W'(held);
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value, int gap,
                        bit drain_first);
    deque_op_t op;
    op.cmd = cmd;
    op.value = value;
    op.gap = gap;
    op.drain_first = drain_first;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // driver: presents one word at a time, honoring per-word gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].drain_first && expected_views.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else if (pending_ops[0].gap > 0) begin
        // gap is spent before the word goes out
        in_wait = pending_ops[0].gap - 1;
        pending_ops[0].gap = 0;
        in_tvalid <= 1'b0;
      end else begin
        in_tdata  <= {{(IN_TDATA_W - CMD_W - VALUE_W){1'b0}},
                      pending_ops[0].value, pending_ops[0].cmd};
        in_tvalid <= 1'b1;
        pending_ops.delete(0);
      end
    end
  end

  // result side back-pressure, calm in some stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took)
        out_wait = ((results_seen / 97) % 3 == 0) ? 0 : $urandom_range(0, 4);
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predicts on input acceptance, checks on output acceptance
  always @(posedge clk) begin
    deque_view_t got, want;
    in_took  <= in_tvalid && in_tready;
    out_took <= out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = deque_view_t'(out_tdata);
        results_seen++;
        if (expected_views.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: front=%h back=%h count=%0d empty=%0b status=%0d",
                     got.front_value, got.back_value, got.count, got.is_empty, got.status);
        end else begin
          want = expected_views[0];
          expected_views.delete(0);
          if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
              got.count !== want.count || got.is_empty !== want.is_empty ||
              got.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result %0d:", results_seen);
              $display("  expected front=%h back=%h count=%0d empty=%0b status=%0d",
                       want.front_value, want.back_value, want.count, want.is_empty,
                       want.status);
              $display("  actual   front=%h back=%h count=%0d empty=%0b status=%0d",
                       got.front_value, got.back_value, got.count, got.is_empty,
                       got.status);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_views.insert(expected_views.size(),
                              deque_apply(in_tdata[CMD_W-1:0],
                                          in_tdata[CMD_W +: VALUE_W]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int made, phase_len, push_pct, r;
    bit calm;
    logic [CMD_W-1:0] cmd;

    // directed: empty pops, idle and unused codes
    add_op(CMD_POP_FRONT, 32'h1234_5678, 0, 1'b0);
    add_op(CMD_POP_BACK, 32'hffff_ffff, 1, 1'b0);
    add_op(CMD_NONE, 32'hdead_beef, 0, 1'b0);
    add_op(3'd5, 32'h0000_0001, 2, 1'b0);
    add_op(3'd6, 32'h8000_0000, 0, 1'b0);
    add_op(3'd7, 32'h7fff_ffff, 3, 1'b0);
    // fill to capacity with extremes first, alternating ends
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      case (i)
        0: add_op(CMD_PUSH_FRONT, 32'h7fff_ffff, $urandom_range(0, 4), 1'b0);
        1: add_op(CMD_PUSH_BACK, 32'h8000_0000, $urandom_range(0, 4), 1'b0);
        2: add_op(CMD_PUSH_FRONT, 32'hffff_ffff, $urandom_range(0, 4), 1'b0);
        3: add_op(CMD_PUSH_BACK, 32'h0000_0000, $urandom_range(0, 4), 1'b0);
        default: add_op((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom(),
                        $urandom_range(0, 4), 1'b0);
      endcase
    end
    // pushes on a full queue, then one pop from each end
    add_op(CMD_PUSH_FRONT, 32'haaaa_5555, 0, 1'b0);
    add_op(CMD_PUSH_BACK, 32'h5555_aaaa, 0, 1'b0);
    add_op(CMD_POP_FRONT, 32'h0, 0, 1'b0);
    add_op(CMD_POP_BACK, 32'h0, 0, 1'b0);

    // random phases, each with its own push/pop bias; the first word of
    // every phase waits until all outstanding results have drained
    made = 0;
    while (made < RANDOM_OPS) begin
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 3))
        0: push_pct = 80;
        1: push_pct = 20;
        2: push_pct = 50;
        default: push_pct = 60;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && made < RANDOM_OPS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          cmd = ($urandom_range(0, 1) != 0) ? CMD_NONE : CMD_W'($urandom_range(5, 7));
        else if ($urandom_range(0, 99) < push_pct)
          cmd = ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
          cmd = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
        add_op(cmd, pick_value(), calm ? 0 : $urandom_range(0, 4), i == 0);
        made++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("ran %0d result words: %0d pushes, %0d pops, %0d no-ops, peak depth %0d",
             results_seen, n_push, n_pop, n_noop, peak_held);
    $display("pushes dropped on full: %0d, pops ignored on empty: %0d, mismatches: %0d",
             n_full_drop, n_empty_pop, errors);
    if (errors == 0 && expected_views.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
